### sv/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and codes for the duplicate message cache.
// ----------------------------------------------------------------------------
package dmc_pkg;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REJECT = 2'd2,
    ACT_EXPIRE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_RESOLVE,
    ST_EXPIRE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] sum;
    logic [31:0] tstamp;
  } entry_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] sum;
    logic [31:0] now;
  } key_t;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctl_t;

endpackage

### sv/dmc_cell.sv
// ----------------------------------------------------------------------------
// dmc_cell
// One table entry of the age-ordered chain: holds an entry, takes the
// neighbor's entry on shift, compares against the current key.
// ----------------------------------------------------------------------------
module dmc_cell (
  input  logic               clk,
  input  dmc_pkg::cell_ctl_t ctl,
  input  dmc_pkg::entry_t    wr_data,
  input  dmc_pkg::entry_t    nb_data,
  input  dmc_pkg::key_t      key,
  input  logic [31:0]        hold_time,
  output dmc_pkg::entry_t    ent,
  output logic               match_r,
  output logic               sum_eq_r,
  output logic               dead
);
  import dmc_pkg::*;

  entry_t      ent_r;
  entry_t      ent_nxt;
  logic [31:0] limit;
  logic        live;
  logic        match_nxt;
  logic        sum_eq_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.shift) begin
      ent_nxt = nb_data;
    end
    if (ctl.write) begin
      ent_nxt = wr_data;
    end
  end

  assign limit      = ent_r.tstamp + hold_time;
  assign live       = limit > key.now;
  assign dead       = key.now > limit;
  assign sum_eq_nxt = ent_r.sum == key.sum;
  assign match_nxt  = (ent_r.addr == key.addr) && sum_eq_nxt && live;

  always_ff @(posedge clk) begin
    ent_r    <= ent_nxt;
    match_r  <= match_nxt;
    sum_eq_r <= sum_eq_nxt;
  end

  assign ent = ent_r;

endmodule

### sv/duplicate_message_cache_unit.sv
// ----------------------------------------------------------------------------
// duplicate_message_cache_unit
// Age-ordered cache of recently seen messages built as a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : command word (lookup, insert, reject newest, expire) with the
//           message address, checksum and current time.
//   out_* : one result word per command: lookup hit flag and fill level.
//   cfg_* : write of the hold time; ready out of reset, write only while idle.
// Cell 0 holds the oldest entry; dropping the oldest shifts the whole chain
// one cell toward cell 0, an insert writes the cell after the newest.
// Flow: lookup and reject pass through compare, resolve and finish, insert
// through compare and finish, expire through compare, an expire step that
// drops the oldest entry while it has outlived the hold time, and finish; the
// sequencer handles one command at a time and takes the next one the cycle after a result is loaded.
// A finished result waits in the output register; the next command is
// accepted once the sequencer is back in idle, so a stalled receiver holds
// at most one command in the finish step.
// Reset empties the table (fill count zero) and clears the hold time;
// entry contents need no clearing.
// ----------------------------------------------------------------------------
module duplicate_message_cache_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [103:0]  in_tdata,   // action[1:0], msg_address[33:2],
                                    // msg_checksum[65:34], current_time[97:66]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,  // found[0], fill_level[5:1]
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);
  import dmc_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [31:0]     hold_r;
  key_t            key_r;
  action_t         act_r;
  logic            found_r, found_nxt;
  logic            out_tvalid_r;
  logic            out_found_r;
  logic [4:0]      out_fill_r;
  logic            load_out;

  logic            shift;
  logic            wr_en;
  logic [IW-1:0]   wr_idx;
  logic            full;
  logic [CW-1:0]   cnt_m1;
  logic [CW+4:0]   cnt_ext;
  entry_t          wr_data;

  entry_t          ent  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match;
  logic [TABLE_DEPTH-1:0] sum_eq;
  logic [TABLE_DEPTH-1:0] dead;
  logic [TABLE_DEPTH-1:0] vmask;

  assign full    = count_r == CW'(TABLE_DEPTH);
  assign cnt_m1  = count_r - 1'b1;
  assign wr_idx  = full ? IW'(TABLE_DEPTH - 1) : count_r[IW-1:0];
  assign wr_data = '{addr: key_r.addr, sum: key_r.sum, tstamp: key_r.now};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    nb;

    assign ctl.shift = shift;
    assign ctl.write = wr_en && (wr_idx == IW'(i));
    assign vmask[i]  = CW'(i) < count_r;

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nb = ent[i];
    end else begin : g_mid
      assign nb = ent[i+1];
    end

    dmc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .wr_data   (wr_data),
      .nb_data   (nb),
      .key       (key_r),
      .hold_time (hold_r),
      .ent       (ent[i]),
      .match_r   (match[i]),
      .sum_eq_r  (sum_eq[i]),
      .dead      (dead[i])
    );
  end

  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign cfg_ready = rst_n;
  assign load_out  = (state_r == ST_FINISH) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    found_nxt = found_r;
    shift     = 1'b0;
    wr_en     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_COMPARE;
          found_nxt = 1'b0;
        end
      end
      ST_COMPARE: begin
        unique case (act_r)
          ACT_INSERT: begin
            if (key_r.addr != '0) begin
              wr_en = 1'b1;
              shift = full;
              if (!full) begin
                count_nxt = count_r + 1'b1;
              end
            end
            state_nxt = ST_FINISH;
          end
          ACT_EXPIRE: state_nxt = ST_EXPIRE;
          default:    state_nxt = ST_RESOLVE;
        endcase
      end
      ST_RESOLVE: begin
        if (act_r == ACT_LOOKUP) begin
          found_nxt = |(match & vmask);
        end else if (count_r != '0 && sum_eq[cnt_m1[IW-1:0]]) begin
          count_nxt = cnt_m1;
        end
        state_nxt = ST_FINISH;
      end
      ST_EXPIRE: begin
        if (count_r != '0 && dead[0]) begin
          shift     = 1'b1;
          count_nxt = cnt_m1;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      hold_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid) begin
        hold_r <= cfg_data;
      end
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign cnt_ext = {5'b0, count_nxt};

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    if (in_tvalid && in_tready) begin
      act_r    <= action_t'(in_tdata[1:0]);
      key_r    <= '{addr: in_tdata[33:2], sum: in_tdata[65:34], now: in_tdata[97:66]};
    end
    if (load_out) begin
      out_found_r <= found_r;
      out_fill_r  <= cnt_ext[4:0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b0, out_fill_r, out_found_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("fill count above table depth");

  a_accept_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == ST_COMPARE)
    else $error("accepted word did not start a compare");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |=> count_r == $past(count_r))
    else $error("fill count changed while idle");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> count_r <= $past(count_r) + 1)
    else $error("fill count grew by more than one");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside finish step");
`endif

endmodule

### dv/duplicate_message_cache_unit_tb.sv
// ----------------------------------------------------------------------------
// duplicate_message_cache_unit_tb
// Self-checking bench for the duplicate message cache. A ring-table
// predictor tracks every accepted command word and produces the expected
// hit flag and fill level. A checker compares each result word, in order,
// against that prediction. The directed tests cover the empty table, the
// hold-time wrap, table overflow, reject and expire. The random phases
// replay message traffic under several hold times, with random idling on
// both sides and one long output stall.
// ----------------------------------------------------------------------------
module duplicate_message_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmc_pkg::*;

  localparam int CACHE_DEPTH   = 16;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int STALL_CYCLES  = 300;
  localparam int DRAIN_CYCLES  = 24;

  typedef struct packed {
    logic       found;
    logic [4:0] fill_level;
  } cache_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [103:0]  in_tdata = '0;   // action, msg_address, msg_checksum, current_time
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [7:0]    out_tdata;       // found, fill_level
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [31:0]   cfg_data = '0;

  duplicate_message_cache_unit #(
    .TABLE_DEPTH(CACHE_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  logic [31:0]   tbl_addr  [CACHE_DEPTH];
  logic [31:0]   tbl_sum   [CACHE_DEPTH];
  logic [31:0]   tbl_stamp [CACHE_DEPTH];
  int unsigned   head_slot = 0;
  int unsigned   entry_count = 0;
  logic [31:0]   model_hold = '0;

  cache_result_t pending_results[$];
  logic [63:0]   recent_keys[$];
  int            mismatches = 0;
  int            sender_idle_pct = 25;
  int            recv_idle_pct = 25;
  bit            stall_request = 1'b0;
  int            stall_left = 0;
  int            quiet_cycles = 0;

  function automatic int unsigned ring_slot(input int unsigned age);
    return (head_slot + age) % CACHE_DEPTH;
  endfunction

  function automatic void drop_oldest();
    head_slot   = ring_slot(1);
    entry_count = entry_count - 1;
  endfunction

  function automatic cache_result_t apply_command(input action_t act, input logic [31:0] addr,
                                                  input logic [31:0] sum, input logic [31:0] now);
    cache_result_t res;
    int unsigned   s;
    logic [31:0]   limit;
    bit            done;
    res.found = 1'b0;
    case (act)
      ACT_LOOKUP: begin
        for (int unsigned k = 0; k < entry_count; k++) begin
          s = ring_slot(k);
          limit = tbl_stamp[s] + model_hold;
          if (tbl_addr[s] == addr && tbl_sum[s] == sum && limit > now) res.found = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (addr != 32'd0) begin
          if (entry_count >= CACHE_DEPTH) drop_oldest();
          s = ring_slot(entry_count);
          tbl_addr[s]  = addr;
          tbl_sum[s]   = sum;
          tbl_stamp[s] = now;
          entry_count  = entry_count + 1;
        end
      end
      ACT_REJECT: begin
        if (entry_count != 0 && tbl_sum[ring_slot(entry_count - 1)] == sum)
          entry_count = entry_count - 1;
      end
      default: begin
        done = 1'b0;
        while (entry_count != 0 && !done) begin
          limit = tbl_stamp[head_slot] + model_hold;
          if (now > limit) drop_oldest();
          else done = 1'b1;
        end
      end
    endcase
    res.fill_level = entry_count[4:0];
    return res;
  endfunction

  task automatic send_command(input action_t act, input logic [31:0] addr,
                              input logic [31:0] sum, input logic [31:0] now);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, now, sum, addr, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_command(act, addr, sum, now));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_hold_time(input logic [31:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    model_hold = value;
  endtask

  always @(posedge clk) begin
    if (stall_request) begin
      stall_left    = STALL_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cache_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result word: expected none actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.found) begin
          $display("%0t found mismatch: expected %0d actual %0d",
                   $time, want.found, out_tdata[0]);
          mismatches++;
        end
        if (out_tdata[5:1] !== want.fill_level) begin
          $display("%0t fill_level mismatch: expected %0d actual %0d",
                   $time, want.fill_level, out_tdata[5:1]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("[duplicate_message_cache_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic test_empty_table();
    send_command(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_command(ACT_REJECT, 32'd0, 32'd0, 32'd0);
    send_command(ACT_EXPIRE, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_command(ACT_INSERT, 32'd0, 32'h1111_2222, 32'd7);
  endtask

  task automatic test_hold_wrap();
    write_hold_time(32'hFFFF_FFFF);
    send_command(ACT_INSERT, 32'h1234_5678, 32'hA5A5_A5A5, 32'd5);
    send_command(ACT_LOOKUP, 32'h1234_5678, 32'hA5A5_A5A5, 32'd3);
    send_command(ACT_LOOKUP, 32'h1234_5678, 32'hA5A5_A5A5, 32'd4);
    send_command(ACT_EXPIRE, 32'd0, 32'd0, 32'd4);
  endtask

  task automatic test_table_overflow();
    logic [31:0] addr;
    logic [31:0] sum;
    write_hold_time(32'd1000);
    for (int i = 1; i <= CACHE_DEPTH + 1; i++) begin
      addr = (i == 1) ? 32'hFFFF_FFFF : 32'(i);
      sum  = (i == CACHE_DEPTH + 1) ? 32'hFFFF_FFFF : 32'(i * 3);
      send_command(ACT_INSERT, addr, sum, 32'(100 + i));
    end
    send_command(ACT_LOOKUP, 32'hFFFF_FFFF, 32'd3, 32'd200);
    send_command(ACT_LOOKUP, 32'd2, 32'd6, 32'd200);
    send_command(ACT_REJECT, 32'd0, 32'hFFFF_FFFE, 32'd200);
    send_command(ACT_REJECT, 32'd0, 32'hFFFF_FFFF, 32'd200);
    send_command(ACT_EXPIRE, 32'd0, 32'd0, 32'd1103);
    send_command(ACT_EXPIRE, 32'd0, 32'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic(input logic [31:0] hold, input logic [31:0] base,
                                     input int items);
    logic [31:0] now;
    logic [31:0] addr;
    logic [31:0] sum;
    logic [63:0] key;
    action_t     act;
    int          r;
    write_hold_time(hold);
    now = base;
    recent_keys.delete();
    repeat (items) begin
      now = now + $urandom_range(0, 6);
      r = $urandom_range(99);
      if (r < 15) begin
        act = action_t'($urandom_range(3));
        send_command(act, $urandom, $urandom, $urandom);
      end else begin
        if (recent_keys.size() != 0 && $urandom_range(1) == 1) begin
          key  = recent_keys[$urandom_range(recent_keys.size() - 1)];
          addr = key[31:0];
          sum  = key[63:32];
        end else begin
          addr = ($urandom_range(49) == 0) ? 32'd0 : $urandom;
          sum  = $urandom;
        end
        r = $urandom_range(99);
        if (r < 40) act = ACT_LOOKUP;
        else if (r < 75) act = ACT_INSERT;
        else if (r < 88) act = ACT_EXPIRE;
        else act = ACT_REJECT;
        if (act == ACT_REJECT && recent_keys.size() != 0 && $urandom_range(3) != 0)
          sum = recent_keys[$][63:32];
        if (act == ACT_INSERT && addr != 32'd0) begin
          recent_keys.push_back({sum, addr});
          if (recent_keys.size() > 8) void'(recent_keys.pop_front());
        end
        send_command(act, addr, sum, now);
      end
    end
    drain_results();
  endtask

  task automatic test_output_stall();
    logic [31:0] now;
    write_hold_time(32'd64);
    sender_idle_pct = 0;
    stall_request   = 1'b1;
    now = $urandom;
    for (int i = 0; i < 24; i++) begin
      now = now + $urandom_range(1, 4);
      send_command((i % 3 == 2) ? ACT_LOOKUP : ACT_INSERT, $urandom, $urandom, now);
    end
    drain_results();
    sender_idle_pct = 25;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_hold_wrap();
    test_table_overflow();
    test_random_traffic(32'd16, $urandom, 100);
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    test_random_traffic(32'hFFFF_FFFF, $urandom, 100);
    sender_idle_pct = 25;
    recv_idle_pct   = 25;
    test_random_traffic(32'd0, 32'hFFFF_FF80, 60);
    test_random_traffic($urandom_range(40, 400), $urandom, 100);
    test_random_traffic(32'h8000_0000, $urandom, 40);
    test_output_stall();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[duplicate_message_cache_unit] OK");
    end else begin
      $display("[duplicate_message_cache_unit] ERROR");
    end
    $finish;
  end

endmodule
